[src/ufp_pkg.sv]
// Package for the UBX frame parser: shared types, codes and reset values.
// Used by the channel interfaces, the frame core and the top level.
package ufp_pkg;

    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int CFG_INDEX_W = 8;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PASS    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MSG_CLASS   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MSG_IDENT   = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h62;
    localparam logic [BYTE_W-1:0] MSG_CLASS_RST   = 8'h01;
    localparam logic [BYTE_W-1:0] MSG_IDENT_RST   = 8'h07;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] msg_class;
        logic [BYTE_W-1:0] msg_ident;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] byte_index;
    } result_t;

endpackage

[src/ufp_byte_if.sv]
// Byte channel interface carrying one received byte per transfer.
// Depends on ufp_pkg.
interface ufp_byte_if
    import ufp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/ufp_result_if.sv]
// Result channel interface: payload bytes and frame check status.
// Depends on ufp_pkg.
interface ufp_result_if
    import ufp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] byte_index;

    modport source (output valid, output kind, output payload_byte, output byte_index,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input byte_index,
                    output ready);
endinterface

[src/ufp_cfg_if.sv]
// Configuration write channel interface: register index and write data.
// Depends on ufp_pkg.
interface ufp_cfg_if
    import ufp_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/ufp_frame_core.sv]
// Frame state machine and Fletcher checksum of the UBX frame parser.
// Depends on ufp_pkg; instantiated by ubx_frame_parser.
module ufp_frame_core
    import ufp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output result_t           res
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_CLASS,
        PH_IDENT,
        PH_LENLO,
        PH_LENHI,
        PH_DATA,
        PH_CHECK
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg, sum_b_next;
    logic [BYTE_W-1:0] check_a_reg, check_a_next;
    logic [BYTE_W-1:0] add_a;
    logic [BYTE_W-1:0] add_b;
    logic [BYTE_W-1:0] count_inc;

    // Fletcher step over the incoming byte.
    assign add_a     = sum_a_reg + rx_byte;
    assign add_b     = sum_b_reg + add_a;
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        check_a_next = check_a_reg;
        res          = '0;
        case (phase_reg)
            PH_HUNT:
            begin
                phase_next = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_HUNT;
            end
            PH_SYNC2:
            begin
                if (rx_byte == cfg.sync_second)
                begin
                    sum_a_next = '0;
                    sum_b_next = '0;
                    phase_next = PH_CLASS;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_CLASS:
            begin
                if (rx_byte == cfg.msg_class)
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_IDENT;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_IDENT:
            begin
                if (rx_byte == cfg.msg_ident)
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_LENLO;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LENLO:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                len_next   = rx_byte;
                phase_next = PH_LENHI;
            end
            PH_LENHI:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                count_next = '0;
                phase_next = (len_reg == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA:
            begin
                sum_a_next       = add_a;
                sum_b_next       = add_b;
                res.valid        = step;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte;
                res.byte_index   = count_reg;
                if (count_inc == len_reg)
                begin
                    count_next = '0;
                    phase_next = PH_CHECK;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_CHECK:
            begin
                if (count_reg == '0)
                begin
                    check_a_next = rx_byte;
                    count_next   = 8'd1;
                end
                else
                begin
                    res.valid  = step;
                    res.kind   = (check_a_reg == sum_a_reg && rx_byte == sum_b_reg)
                                 ? KIND_PASS : KIND_FAIL;
                    count_next = '0;
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            len_reg     <= '0;
            count_reg   <= '0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            check_a_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            check_a_reg <= check_a_next;
        end
    end

`ifndef SYNTHESIS
    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> step)
        else $error("result raised without a byte step");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == KIND_PAYLOAD) |-> (res.byte_index < len_reg))
        else $error("payload index not below payload length");

    a_status_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.valid && res.kind != KIND_PAYLOAD) |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunting after status");
`endif

endmodule

[src/ubx_frame_parser.sv]
// A byte is registered in the input register on its rx transfer; when it
// advances, its result, if any, is registered and offered on the result channel.
// Throughput: one byte per cycle; the input register and the result register
// both advance together, so rx stalls only while a result waits to be taken.
// Reset (rst_n low, asynchronous) returns the parser to hunting for the first
// sync byte, empties both registers and restores the default sync/class/id.
module ubx_frame_parser
    import ufp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ufp_byte_if.sink     rx,
    ufp_result_if.source result,
    ufp_cfg_if.sink      cfg
);

    // Configuration registers. The user must write them only while the
    // parser is idle, which is not enforced; writes are always ready and apply at once.
    cfg_t cfg_reg, cfg_next;

    // Input register: one received byte waiting to be parsed.
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;

    // Result register: the output stage toward the consumer.
    logic              res_valid_reg, res_valid_next;
    logic [KIND_W-1:0] res_kind_reg;
    logic [BYTE_W-1:0] res_payload_reg;
    logic [BYTE_W-1:0] res_index_reg;

    result_t core_res;
    logic    advance;
    logic    rx_fire;

    // The parsed byte moves on when the result stage is free or drains in
    // the same cycle. A byte without a result still needs that slot free so
    // that results stay in order with their frame state.
    assign advance  = in_valid_reg && (!res_valid_reg || result.ready);
    assign rx.ready = !in_valid_reg || advance;
    assign rx_fire  = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    ufp_frame_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .res     (core_res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SYNC_FIRST:  cfg_next.sync_first  = cfg.data;
                CFG_SYNC_SECOND: cfg_next.sync_second = cfg.data;
                CFG_MSG_CLASS:   cfg_next.msg_class   = cfg.data;
                CFG_MSG_IDENT:   cfg_next.msg_ident   = cfg.data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (rx_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            res_valid_next = core_res.valid;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
            cfg_reg.msg_class   <= MSG_CLASS_RST;
            cfg_reg.msg_ident   <= MSG_IDENT_RST;
            in_valid_reg        <= 1'b0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (rx_fire)
            in_byte_reg <= rx.rx_byte;
        if (advance && core_res.valid)
        begin
            res_kind_reg    <= core_res.kind;
            res_payload_reg <= core_res.payload_byte;
            res_index_reg   <= core_res.byte_index;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.kind         = res_kind_reg;
    assign result.payload_byte = res_payload_reg;
    assign result.byte_index   = res_index_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready) |-> !advance)
        else $error("result register overwritten before transfer");

    a_rx_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> rx.ready)
        else $error("empty input register refused a byte");

    a_result_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid_reg && !$past(advance)) |-> !result.valid)
        else $error("result offered without a parsed byte");
`endif

endmodule
